// ===== sv/mcrqs_pkg.sv =====
package mcrqs_pkg;

    localparam logic [2:0] OP_IDLE      = 3'd0;
    localparam logic [2:0] OP_PREEMPT   = 3'd1;
    localparam logic [2:0] OP_YIELD     = 3'd2;
    localparam logic [2:0] OP_TERMINATE = 3'd3;
    localparam logic [2:0] OP_WAKE      = 3'd4;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_RR   = 2'd1;
    localparam logic [1:0] MODE_PRIO = 2'd2;

    localparam logic [1:0] ACT_SWITCH   = 2'd0;
    localparam logic [1:0] ACT_PREEMPT  = 2'd1;
    localparam logic [1:0] ACT_OVERFLOW = 2'd2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_SLICE  = 2'd1;
    localparam logic [1:0] CFG_ACTIVE = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] cpu_index;
        logic [7:0] proc_id;
        logic [3:0] proc_priority;
    } t_item;

    typedef struct packed {
        logic [1:0]  action_kind;
        logic [3:0]  target_cpu;
        logic [7:0]  chosen_proc;
        logic        runs_process;
        logic [15:0] granted_slice;
    } t_res;

    typedef struct packed {
        logic [7:0] proc;
        logic [3:0] prio;
    } t_qent;

    // one CPU table row, used for both write and read
    typedef struct packed {
        logic       busy;
        logic       waiting;
        logic [7:0] proc;
        logic [3:0] prio;
    } t_cpu_row;

endpackage

// ===== sv/mcrqs_qmem.sv =====
module mcrqs_qmem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  mcrqs_pkg::t_qent     i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output mcrqs_pkg::t_qent     o_rdata
);
    import mcrqs_pkg::*;

    t_qent r_mem [DEPTH];
    t_qent r_rdata;

    // write and registered read, one port each
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/mcrqs_cpu_tbl.sv =====
module mcrqs_cpu_tbl #(
    parameter int NCPU = 16,
    parameter int CW   = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [CW-1:0]          i_sel,
    input  logic                   i_we,
    input  mcrqs_pkg::t_cpu_row    i_wrow,
    output mcrqs_pkg::t_cpu_row    o_rrow,
    output logic [NCPU-1:0]        o_busy
);
    import mcrqs_pkg::*;

    t_cpu_row r_row [NCPU];

    // update the selected row; reset clears all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCPU; k++) begin
                r_row[k] <= '0;
            end
        end else if (i_we) begin
            r_row[i_sel] <= i_wrow;
        end
    end

    assign o_rrow = r_row[i_sel];

    always_comb begin
        for (int k = 0; k < NCPU; k++) begin
            o_busy[k] = r_row[k].busy;
        end
    end
endmodule

// ===== sv/multi_cpu_ready_queue_scheduler.sv =====
// Sequence per item: decode, then dispatch from the queue head or idle the CPU; a wake
// first scans the CPUs for a waiting one, a priority insert scans and shifts queue entries,
// and a preempt request scans the active CPUs.
// Flow: one item at a time; the next beat is taken once the sequencer is back in idle,
// and the emit step waits while an earlier result is still stalled.
// Reset: synchronous active low; queue empty, all CPUs idle, config registers at defaults.
module multi_cpu_ready_queue_scheduler #(
    parameter int MAX_CPUS     = 16,
    parameter int QUEUE_DEPTH  = 64,
    parameter int TOP_PRIORITY = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  mcrqs_pkg::t_item   i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output mcrqs_pkg::t_res    o_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import mcrqs_pkg::*;

    localparam int CW  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CNW = $clog2(MAX_CPUS + 1);
    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int FW  = AW + 1;
    localparam int PW  = $clog2(TOP_PRIORITY + 2);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_WSCAN = 5'd2;
    localparam logic [4:0] S_ITD   = 5'd3;
    localparam logic [4:0] S_HCHK  = 5'd4;
    localparam logic [4:0] S_POPRD = 5'd5;
    localparam logic [4:0] S_POP   = 5'd6;
    localparam logic [4:0] S_INS   = 5'd7;
    localparam logic [4:0] S_SRD   = 5'd8;
    localparam logic [4:0] S_SCMP  = 5'd9;
    localparam logic [4:0] S_SHRD  = 5'd10;
    localparam logic [4:0] S_SHWR  = 5'd11;
    localparam logic [4:0] S_PUT   = 5'd12;
    localparam logic [4:0] S_PCHK  = 5'd13;
    localparam logic [4:0] S_PSCAN = 5'd14;
    localparam logic [4:0] S_RUN   = 5'd15;
    localparam logic [4:0] S_EMIT  = 5'd16;

    function automatic logic [AW-1:0] qaddr(input logic [AW-1:0] base,
                                            input logic [FW-1:0] off);
        logic [FW-1:0] sum;
        sum = {1'b0, base} + off;
        if (32'(sum) >= QUEUE_DEPTH) begin
            sum = sum - FW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [4:0]    r_state, n_state;
    logic [1:0]    r_mode;
    logic [15:0]   r_slice;
    logic [4:0]    r_active;
    logic [2:0]    r_op, n_op;
    logic [3:0]    r_cpu, n_cpu;
    logic [7:0]    r_proc, n_proc;
    logic [3:0]    r_prio, n_prio;
    logic [7:0]    r_dproc, n_dproc;
    logic [3:0]    r_dprio, n_dprio;
    logic [CW-1:0] r_sel, n_sel;
    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_k, n_k;
    logic [FW-1:0] r_i, n_i;
    logic          r_after, n_after;
    logic [PW-1:0] r_best, n_best;
    logic          r_found, n_found;
    logic [CW-1:0] r_fsel, n_fsel;
    t_res          r_pend, n_pend;
    logic          r_ovalid, n_ovalid;
    t_res          r_out, n_out;

    logic [CNW-1:0]  w_n;
    logic            w_last;
    logic [MAX_CPUS-1:0] w_busy, w_mask;
    t_cpu_row        w_rrow, w_wrow;
    logic            w_cwe;
    logic            w_qwe;
    logic [AW-1:0]   w_waddr, w_raddr;
    t_qent           w_wdata, w_rdata;
    logic [15:0]     w_gslice;

    mcrqs_qmem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_qmem (
        .i_clk(i_clk), .i_we(w_qwe), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    mcrqs_cpu_tbl #(.NCPU(MAX_CPUS), .CW(CW)) u_cpu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sel(r_sel), .i_we(w_cwe),
        .i_wrow(w_wrow), .o_rrow(w_rrow), .o_busy(w_busy)
    );

    // clamp the active CPU count
    always_comb begin
        if (r_active == 5'd0) begin
            w_n = CNW'(1);
        end else if (32'(r_active) > MAX_CPUS) begin
            w_n = CNW'(MAX_CPUS);
        end else begin
            w_n = CNW'(r_active);
        end
        for (int k = 0; k < MAX_CPUS; k++) begin
            w_mask[k] = (k < 32'(w_n));
        end
    end

    assign w_last   = (32'(r_sel) + 1 == 32'(w_n));
    assign w_gslice = (r_mode == MODE_RR) ? r_slice : 16'd0;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_res       = r_out;

    // sequencer
    always_comb begin
        n_state = r_state;  n_op = r_op;  n_cpu = r_cpu;
        n_proc = r_proc;    n_prio = r_prio;
        n_dproc = r_dproc;  n_dprio = r_dprio;
        n_sel = r_sel;      n_head = r_head;  n_fill = r_fill;
        n_k = r_k;          n_i = r_i;        n_after = r_after;
        n_best = r_best;    n_found = r_found; n_fsel = r_fsel;
        n_pend = r_pend;
        n_ovalid = r_ovalid && i_stall;
        n_out = r_out;
        w_cwe = 1'b0;       w_wrow = w_rrow;
        w_qwe = 1'b0;       w_waddr = r_head;  w_wdata = '0;
        w_raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_item.operation;
                    n_cpu   = i_item.cpu_index;
                    n_proc  = i_item.proc_id;
                    n_prio  = i_item.proc_priority;
                    n_sel   = CW'(i_item.cpu_index);
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                if (r_op == OP_WAKE) begin
                    n_sel   = '0;
                    n_state = S_WSCAN;
                end else if (r_op > OP_WAKE || 32'(r_cpu) >= 32'(w_n)) begin
                    n_state = S_IDLE;
                end else if (r_op == OP_IDLE) begin
                    if (!w_rrow.busy) begin
                        if (r_fill == '0) begin
                            w_cwe = 1'b1;
                            w_wrow.waiting = 1'b1;
                        end else begin
                            n_state = S_POPRD;
                        end
                    end
                end else if (w_rrow.busy) begin
                    if (r_op == OP_PREEMPT) begin
                        n_proc  = w_rrow.proc;
                        n_prio  = w_rrow.prio;
                        n_state = S_ITD;
                    end else if (r_fill == '0) begin
                        w_cwe  = 1'b1;
                        w_wrow = '0;
                        n_pend = '{ACT_SWITCH, r_cpu, 8'd0, 1'b0, 16'd0};
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_POPRD;
                    end
                end
            end
            S_WSCAN: begin
                if (w_rrow.waiting && !w_rrow.busy) begin
                    n_state = S_ITD;
                end else if (w_last) begin
                    if (32'(r_fill) >= QUEUE_DEPTH) begin
                        n_pend  = '{ACT_OVERFLOW, 4'd0, r_proc, 1'b0, 16'd0};
                        n_state = S_EMIT;
                    end else begin
                        n_after = 1'b0;
                        n_state = S_INS;
                    end
                end else begin
                    n_sel = r_sel + 1'b1;
                end
            end
            S_ITD: begin
                if (r_fill == '0) begin
                    n_dproc = r_proc;
                    n_dprio = r_prio;
                    n_state = S_RUN;
                end else begin
                    w_raddr = r_head;
                    n_state = S_HCHK;
                end
            end
            S_HCHK: begin
                if (r_mode == MODE_PRIO && r_prio > w_rdata.prio) begin
                    n_dproc = r_proc;
                    n_dprio = r_prio;
                    n_state = S_RUN;
                end else begin
                    n_dproc = w_rdata.proc;
                    n_dprio = w_rdata.prio;
                    n_head  = qaddr(r_head, FW'(1));
                    n_fill  = r_fill - 1'b1;
                    n_after = 1'b1;
                    n_state = S_INS;
                end
            end
            S_POPRD: begin
                w_raddr = r_head;
                n_state = S_POP;
            end
            S_POP: begin
                n_dproc = w_rdata.proc;
                n_dprio = w_rdata.prio;
                n_head  = qaddr(r_head, FW'(1));
                n_fill  = r_fill - 1'b1;
                n_state = S_RUN;
            end
            S_INS: begin
                if (r_mode == MODE_PRIO) begin
                    n_k     = '0;
                    n_state = S_SRD;
                end else begin
                    n_k     = r_fill;
                    n_state = S_PUT;
                end
            end
            S_SRD: begin
                if (r_k == r_fill) begin
                    n_state = S_PUT;
                end else begin
                    w_raddr = qaddr(r_head, r_k);
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (w_rdata.prio < r_prio) begin
                    n_i     = r_fill;
                    n_state = S_SHRD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_SHRD: begin
                if (r_i == r_k) begin
                    n_state = S_PUT;
                end else begin
                    w_raddr = qaddr(r_head, r_i - 1'b1);
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                w_qwe   = 1'b1;
                w_waddr = qaddr(r_head, r_i);
                w_wdata = w_rdata;
                n_i     = r_i - 1'b1;
                n_state = S_SHRD;
            end
            S_PUT: begin
                w_qwe   = 1'b1;
                w_waddr = qaddr(r_head, r_k);
                w_wdata = '{r_proc, r_prio};
                n_fill  = r_fill + 1'b1;
                n_state = r_after ? S_RUN : S_PCHK;
            end
            S_PCHK: begin
                n_state = S_IDLE;
                if (r_mode == MODE_PRIO && ((w_busy & w_mask) == w_mask)) begin
                    n_sel   = '0;
                    n_best  = PW'(TOP_PRIORITY + 1);
                    n_found = 1'b0;
                    n_state = S_PSCAN;
                end
            end
            S_PSCAN: begin
                if (32'(w_rrow.prio) < 32'(r_best) && w_rrow.prio < r_prio) begin
                    n_best  = PW'(w_rrow.prio);
                    n_found = 1'b1;
                    n_fsel  = r_sel;
                end
                if (w_last) begin
                    n_state = S_IDLE;
                    if (n_found) begin
                        n_pend  = '{ACT_PREEMPT, 4'(n_fsel), r_proc, 1'b0, 16'd0};
                        n_state = S_EMIT;
                    end
                end else begin
                    n_sel = r_sel + 1'b1;
                end
            end
            S_RUN: begin
                w_cwe   = 1'b1;
                w_wrow  = '{1'b1, 1'b0, r_dproc, r_dprio};
                n_pend  = '{ACT_SWITCH, 4'(r_sel), r_dproc, 1'b1, w_gslice};
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!n_ovalid) begin
                    n_ovalid = 1'b1;
                    n_out    = r_pend;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_head   <= '0;
            r_fill   <= '0;
            r_mode   <= MODE_FIFO;
            r_slice  <= 16'd0;
            r_active <= 5'd1;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_head   <= n_head;
            r_fill   <= n_fill;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                    CFG_SLICE:  r_slice  <= i_cfg_data;
                    CFG_ACTIVE: r_active <= i_cfg_data[4:0];
                    default:    ;
                endcase
            end
        end
    end

    // payload and scratch
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;    r_cpu   <= n_cpu;
        r_proc  <= n_proc;  r_prio  <= n_prio;
        r_dproc <= n_dproc; r_dprio <= n_dprio;
        r_sel   <= n_sel;   r_k     <= n_k;    r_i <= n_i;
        r_after <= n_after; r_best  <= n_best;
        r_found <= n_found; r_fsel  <= n_fsel;
        r_pend  <= n_pend;  r_out   <= n_out;
    end
endmodule

// ===== sv/mcrqs_checker.sv =====
module mcrqs_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input mcrqs_pkg::t_res  o_res
);
    import mcrqs_pkg::*;

    // hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("result beat dropped under stall");

    // block is busy right after taking a beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted beat without going busy");

    // an idle switch carries no process and no slice
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.action_kind == ACT_SWITCH && !o_res.runs_process
        |-> o_res.chosen_proc == 8'd0 && o_res.granted_slice == 16'd0)
        else $error("idle switch with payload");

    // requests and overflow never run a process
    a_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.action_kind != ACT_SWITCH
        |-> !o_res.runs_process && o_res.granted_slice == 16'd0)
        else $error("non-switch result runs a process");
endmodule

bind multi_cpu_ready_queue_scheduler mcrqs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res)
);
